[sv/pla_pkg.sv]
// Package for the positional list block: operation and status codes,
// per-cell command type and the control word broadcast along the cell chain.
// No dependencies.
package pla_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CTRL_IDX_W     = 6;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_TAIL = 3'd4,
        OP_DEL_POS  = 3'd5,
        OP_LIST     = 3'd6,
        OP_RSVD     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd              cmd;
        logic [CTRL_IDX_W-1:0]  pos;
        logic [CTRL_IDX_W-1:0]  last;
    } t_cell_ctrl;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

endpackage

[sv/pla_cell.sv]
// One list slot of the cell chain: holds one entry and takes its neighbour's
// entry, the new value or the head entry as the broadcast control word says.
// Depends on pla_pkg.
module pla_cell #(
    parameter int DATA_WIDTH = pla_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  logic                   i_clk,
    input  pla_pkg::t_cell_ctrl    i_ctrl,
    input  logic [DATA_WIDTH-1:0]  i_ins_value,
    input  logic [DATA_WIDTH-1:0]  i_left,
    input  logic [DATA_WIDTH-1:0]  i_right,
    input  logic [DATA_WIDTH-1:0]  i_head,
    output logic [DATA_WIDTH-1:0]  o_data
);

    localparam logic [pla_pkg::CTRL_IDX_W-1:0] MY_IDX = pla_pkg::CTRL_IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.cmd)
            pla_pkg::CELL_INS: begin
                if (MY_IDX == i_ctrl.pos) begin
                    n_data = i_ins_value;
                end else if (MY_IDX > i_ctrl.pos) begin
                    n_data = i_left;
                end
            end
            pla_pkg::CELL_DEL: begin
                if (MY_IDX >= i_ctrl.pos) begin
                    n_data = i_right;
                end
            end
            pla_pkg::CELL_ROT: begin
                if (MY_IDX == i_ctrl.last) begin
                    n_data = i_head;
                end else begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[sv/positional_list_insert_delete.sv]
// Positional list: an update's status word is valid in the cycle after acceptance.
// A list command streams one word per cycle while the output slot is free, head first,
// by rotating the cell chain: the state register enters listing, then each word is
// registered in the output slot up to the last entry (an empty list gives one status word).
// A new input word is taken only when no listing runs and the output slot is free.
// Synchronous active-low reset clears entry count, state and output valid, not the cells.
module positional_list_insert_delete #(
    parameter int CAPACITY   = pla_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pla_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value_res,
    output logic [6:0]         o_index,
    output logic [1:0]         o_status,
    output logic [6:0]         o_entry_count,
    output logic               o_last_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = pla_pkg::CTRL_IDX_W;

    logic [DATA_WIDTH-1:0] w_cell [CAPACITY];
    logic [DATA_WIDTH-1:0] w_ins_value;
    logic signed [63:0]    w_in_ext;
    logic signed [63:0]    w_head_ext;
    pla_pkg::t_cell_ctrl   w_ctrl;

    pla_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_lidx, n_lidx;

    logic               r_out_valid;
    logic signed [31:0] r_value_res, n_value_res;
    logic [6:0]         r_index, n_index;
    pla_pkg::t_status   r_status, n_status;
    logic [6:0]         r_entry_count, n_entry_count;
    logic               r_last, n_last;
    logic               w_out_load;

    logic       w_slot_free;
    logic       w_take_in;
    logic       w_full;
    logic       w_empty;
    logic       w_list_last;
    logic [8:0] w_pos9;
    logic [8:0] w_cnt9;
    logic [8:0] w_p9;
    pla_pkg::t_op w_op;

    assign w_in_ext    = 64'(i_value);
    assign w_ins_value = w_in_ext[DATA_WIDTH-1:0];
    assign w_head_ext  = 64'(signed'(w_cell[0]));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell[gi+1];
            end
            pla_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_ins_value (w_ins_value),
                .i_left      (w_left),
                .i_right     (w_right),
                .i_head      (w_cell[0]),
                .o_data      (w_cell[gi])
            );
        end
    endgenerate

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == pla_pkg::S_IDLE) && w_slot_free;
    assign w_take_in   = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_list_last = (r_lidx == r_count - CW'(1));
    assign w_pos9      = {1'b0, i_position};
    assign w_cnt9      = 9'(r_count);
    assign w_op        = pla_pkg::t_op'(i_operation);

    always_comb begin
        n_state = r_state;
        case (r_state)
            pla_pkg::S_IDLE: begin
                if (w_take_in && w_op == pla_pkg::OP_LIST && !w_empty) begin
                    n_state = pla_pkg::S_LIST;
                end
            end
            pla_pkg::S_LIST: begin
                if (w_slot_free && w_list_last) begin
                    n_state = pla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pla_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctrl.cmd    = pla_pkg::CELL_HOLD;
        w_ctrl.pos    = '0;
        w_ctrl.last   = IW'(r_count - CW'(1));
        w_p9          = '0;
        n_count       = r_count;
        n_lidx        = r_lidx;
        w_out_load    = 1'b0;
        n_value_res   = '0;
        n_index       = '0;
        n_status      = pla_pkg::ST_OK;
        n_entry_count = 7'(r_count);
        n_last        = 1'b1;
        case (r_state)
            pla_pkg::S_IDLE: begin
                n_lidx = '0;
                if (w_take_in) begin
                    w_out_load = 1'b1;
                    case (w_op)
                        pla_pkg::OP_INS_HEAD, pla_pkg::OP_INS_TAIL, pla_pkg::OP_INS_POS: begin
                            if (w_full) begin
                                n_status = pla_pkg::ST_FULL;
                            end else if (w_op == pla_pkg::OP_INS_POS &&
                                         (w_pos9 == '0 || w_pos9 > w_cnt9 + 9'd1)) begin
                                n_status = pla_pkg::ST_BADPOS;
                            end else begin
                                if (w_op == pla_pkg::OP_INS_TAIL) begin
                                    w_p9 = w_cnt9;
                                end else if (w_op == pla_pkg::OP_INS_POS) begin
                                    w_p9 = w_pos9 - 9'd1;
                                end
                                w_ctrl.cmd    = pla_pkg::CELL_INS;
                                w_ctrl.pos    = w_p9[IW-1:0];
                                n_count       = r_count + CW'(1);
                                n_entry_count = 7'(r_count + CW'(1));
                            end
                        end
                        pla_pkg::OP_DEL_HEAD, pla_pkg::OP_DEL_TAIL, pla_pkg::OP_DEL_POS: begin
                            if (w_empty) begin
                                n_status = pla_pkg::ST_EMPTY;
                            end else if (w_op == pla_pkg::OP_DEL_POS &&
                                         (w_pos9 == '0 || w_pos9 > w_cnt9)) begin
                                n_status = pla_pkg::ST_BADPOS;
                            end else begin
                                if (w_op == pla_pkg::OP_DEL_TAIL) begin
                                    w_p9 = w_cnt9 - 9'd1;
                                end else if (w_op == pla_pkg::OP_DEL_POS) begin
                                    w_p9 = w_pos9 - 9'd1;
                                end
                                w_ctrl.cmd    = pla_pkg::CELL_DEL;
                                w_ctrl.pos    = w_p9[IW-1:0];
                                n_count       = r_count - CW'(1);
                                n_entry_count = 7'(r_count - CW'(1));
                            end
                        end
                        pla_pkg::OP_LIST: begin
                            if (w_empty) begin
                                n_status = pla_pkg::ST_EMPTY;
                            end else begin
                                w_out_load = 1'b0;
                            end
                        end
                        default: begin
                            n_status = pla_pkg::ST_OK;
                        end
                    endcase
                end
            end
            pla_pkg::S_LIST: begin
                if (w_slot_free) begin
                    w_out_load  = 1'b1;
                    w_ctrl.cmd  = pla_pkg::CELL_ROT;
                    n_value_res = w_head_ext[31:0];
                    n_index     = 7'(r_lidx) + 7'd1;
                    n_last      = w_list_last;
                    n_lidx      = r_lidx + CW'(1);
                end
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pla_pkg::S_IDLE;
            r_count     <= '0;
            r_lidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_lidx  <= n_lidx;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_value_res   <= n_value_res;
            r_index       <= n_index;
            r_status      <= n_status;
            r_entry_count <= n_entry_count;
            r_last        <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_res   = r_value_res;
    assign o_index       = r_index;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_last_result = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pla_pkg::S_LIST |-> r_count != '0)
        else $error("listing an empty list");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pla_pkg::S_LIST |-> !o_in_ready)
        else $error("input taken during listing");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take_in && w_full && (w_op == pla_pkg::OP_INS_HEAD ||
            w_op == pla_pkg::OP_INS_TAIL || w_op == pla_pkg::OP_INS_POS))
        |=> (o_out_valid && o_status == pla_pkg::ST_FULL && $stable(r_count)))
        else $error("insert into full list not flagged");

    a_partial_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_result) |-> r_state == pla_pkg::S_LIST)
        else $error("non-final word outside listing");

endmodule

[dv/positional_list_insert_delete_tb.sv]
// Self-checking testbench for positional_list_insert_delete: directed and random list commands
// are driven over valid/ready, and every result word is checked against a local list predictor.
// Depends on pla_pkg and the positional_list_insert_delete RTL.
module positional_list_insert_delete_tb;

    localparam int DEPTH         = pla_pkg::CAPACITY_DEF;
    localparam int RANDOM_WORDS  = 480;
    localparam int SETTLE_CYCLES = 24;
    localparam int RUN_LIMIT     = 600000;

    typedef struct {
        pla_pkg::t_op       op;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_command;

    typedef struct {
        logic signed [31:0] value;
        logic [6:0]         index;
        pla_pkg::t_status   status;
        logic [6:0]         count;
        logic               last;
    } t_list_word;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               i_out_ready   = 1'b0;
    logic [2:0]         i_operation   = '0;
    logic signed [31:0] i_value       = '0;
    logic [7:0]         i_position    = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_value_res;
    logic [6:0]         o_index;
    logic [1:0]         o_status;
    logic [6:0]         o_entry_count;
    logic               o_last_result;

    t_command           pending_cmds[$];
    t_command           current_cmd;
    t_list_word         expected_words[$];
    logic signed [31:0] entries[DEPTH];
    int                 entry_total        = 0;
    int                 gen_count          = 0;
    int                 words_sent         = 0;
    int                 total_words        = 1;
    int                 sender_gap_pct     = 11;
    int                 receiver_stall_pct = 67;
    int                 mismatch_count     = 0;
    bit                 word_taken         = 1'b0;

    positional_list_insert_delete DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value_res   (o_value_res),
        .o_index       (o_index),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_last_result (o_last_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Track the entry count at generation time so positions can aim at the valid range.
    task automatic queue_cmd(input pla_pkg::t_op op, input logic signed [31:0] v,
                             input logic [7:0] p);
        t_command c;
        c.op       = op;
        c.value    = v;
        c.position = p;
        pending_cmds.push_back(c);
        case (op)
            pla_pkg::OP_INS_HEAD, pla_pkg::OP_INS_TAIL: begin
                if (gen_count < DEPTH) gen_count++;
            end
            pla_pkg::OP_INS_POS: begin
                if (gen_count < DEPTH && p >= 1 && p <= gen_count + 1) gen_count++;
            end
            pla_pkg::OP_DEL_HEAD, pla_pkg::OP_DEL_TAIL: begin
                if (gen_count > 0) gen_count--;
            end
            pla_pkg::OP_DEL_POS: begin
                if (gen_count > 0 && p >= 1 && p <= gen_count) gen_count--;
            end
            default: ;
        endcase
    endtask

    task automatic apply_command(input t_command c);
        pla_pkg::t_status s;
        t_list_word       w;
        int               k;
        int               i;
        s = pla_pkg::ST_OK;
        case (c.op)
            pla_pkg::OP_INS_HEAD, pla_pkg::OP_INS_TAIL, pla_pkg::OP_INS_POS: begin
                if (entry_total >= DEPTH) begin
                    s = pla_pkg::ST_FULL;
                end else if (c.op == pla_pkg::OP_INS_POS &&
                             (c.position < 1 || c.position > entry_total + 1)) begin
                    s = pla_pkg::ST_BADPOS;
                end else begin
                    k = (c.op == pla_pkg::OP_INS_HEAD) ? 0 :
                        (c.op == pla_pkg::OP_INS_TAIL) ? entry_total : int'(c.position) - 1;
                    for (i = entry_total; i > k; i--) entries[i] = entries[i-1];
                    entries[k] = c.value;
                    entry_total++;
                end
            end
            pla_pkg::OP_DEL_HEAD, pla_pkg::OP_DEL_TAIL, pla_pkg::OP_DEL_POS: begin
                if (entry_total == 0) begin
                    s = pla_pkg::ST_EMPTY;
                end else if (c.op == pla_pkg::OP_DEL_POS &&
                             (c.position < 1 || c.position > entry_total)) begin
                    s = pla_pkg::ST_BADPOS;
                end else begin
                    k = (c.op == pla_pkg::OP_DEL_HEAD) ? 0 :
                        (c.op == pla_pkg::OP_DEL_TAIL) ? entry_total - 1 :
                        int'(c.position) - 1;
                    for (i = k; i + 1 < entry_total; i++) entries[i] = entries[i+1];
                    entry_total--;
                end
            end
            pla_pkg::OP_LIST: begin
                if (entry_total == 0) s = pla_pkg::ST_EMPTY;
            end
            default: ;
        endcase
        w.count = 7'(entry_total);
        if (c.op == pla_pkg::OP_LIST && entry_total > 0) begin
            for (i = 0; i < entry_total; i++) begin
                w.value  = entries[i];
                w.index  = 7'(i + 1);
                w.status = pla_pkg::ST_OK;
                w.last   = (i + 1 == entry_total);
                expected_words.push_back(w);
            end
        end else begin
            w.value  = '0;
            w.index  = '0;
            w.status = s;
            w.last   = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Predict on acceptance and move the idling phases along.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            apply_command(current_cmd);
            word_taken = 1'b1;
            words_sent++;
            if (words_sent * 3 >= total_words * 2) begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end else if (words_sent * 3 >= total_words) begin
                sender_gap_pct     = 67;
                receiver_stall_pct = 11;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            word_taken = 1'b0;
            if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
                current_cmd = pending_cmds.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= current_cmd.op;
                i_value     <= current_cmd.value;
                i_position  <= current_cmd.position;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_list_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none, got value %0h index %0d",
                         $time, o_value_res, o_index);
            end else begin
                want = expected_words.pop_front();
                check_field("value_res", want.value, o_value_res);
                check_field("index", 32'(want.index), 32'(o_index));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("entry_count", 32'(want.count), 32'(o_entry_count));
                check_field("last_result", 32'(want.last), 32'(o_last_result));
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("positional_list_insert_delete: mismatch");
        $finish;
    end

    initial begin
        int           roll;
        int           lim;
        bit           filling;
        bit           want_insert;
        pla_pkg::t_op op;
        logic [7:0]   pos;

        queue_cmd(pla_pkg::OP_LIST, 0, 8'd0);
        queue_cmd(pla_pkg::OP_DEL_HEAD, 0, 8'd0);
        queue_cmd(pla_pkg::OP_DEL_TAIL, 0, 8'd0);
        queue_cmd(pla_pkg::OP_DEL_POS, 0, 8'd1);
        queue_cmd(pla_pkg::OP_INS_POS, 5, 8'd0);
        queue_cmd(pla_pkg::OP_INS_POS, 5, 8'd2);
        queue_cmd(pla_pkg::OP_INS_POS, 0, 8'd1);
        queue_cmd(pla_pkg::OP_INS_HEAD, 32'sh7fffffff, 8'd0);
        queue_cmd(pla_pkg::OP_INS_TAIL, 32'sh80000000, 8'd0);
        queue_cmd(pla_pkg::OP_INS_POS, -1, 8'd4);
        queue_cmd(pla_pkg::OP_INS_POS, 32'sh5a5aa5a5, 8'd2);
        queue_cmd(pla_pkg::OP_LIST, 0, 8'd0);
        queue_cmd(pla_pkg::OP_DEL_POS, 0, 8'd0);
        queue_cmd(pla_pkg::OP_DEL_POS, 0, 8'd6);
        queue_cmd(pla_pkg::OP_INS_POS, -1, 8'd255);
        queue_cmd(pla_pkg::OP_DEL_POS, 0, 8'd255);
        queue_cmd(pla_pkg::OP_RSVD, -1, 8'd255);
        queue_cmd(pla_pkg::OP_DEL_POS, 0, 8'd3);
        queue_cmd(pla_pkg::OP_DEL_HEAD, 0, 8'd0);
        queue_cmd(pla_pkg::OP_DEL_TAIL, 0, 8'd0);
        queue_cmd(pla_pkg::OP_LIST, 0, 8'd0);

        // Alternate fill and drain runs so the full and empty limits are hit repeatedly.
        filling = 1'b1;
        repeat (RANDOM_WORDS) begin
            if (filling && gen_count == DEPTH && $urandom_range(2) == 0) filling = 1'b0;
            else if (!filling && gen_count == 0 && $urandom_range(2) == 0) filling = 1'b1;
            roll        = $urandom_range(99);
            want_insert = (roll < 70) ? filling : !filling;
            if (roll < 85) begin
                op = want_insert ? pla_pkg::t_op'(3'($urandom_range(2))) :
                                   pla_pkg::t_op'(3'(3 + $urandom_range(2)));
            end else if (roll < 95) begin
                op = pla_pkg::OP_LIST;
            end else if (roll < 97) begin
                op = pla_pkg::OP_RSVD;
            end else begin
                op = pla_pkg::t_op'(3'($urandom_range(7)));
            end
            lim = (op == pla_pkg::OP_INS_POS) ? gen_count + 1 :
                  ((gen_count > 0) ? gen_count : 1);
            if ($urandom_range(4) == 0) pos = 8'($urandom_range(255));
            else pos = 8'($urandom_range(lim, 1));
            queue_cmd(op, $urandom(), pos);
        end
        total_words = pending_cmds.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("positional_list_insert_delete: match");
        end else begin
            $display("positional_list_insert_delete: mismatch");
        end
        $finish;
    end

endmodule
